>>> rtl/tmsd_pkg.sv
`default_nettype none
package tmsd_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [3:0]  field_number;
    logic [31:0] field_value;
    logic [2:0]  end_status;
    logic        last_of_run;
  } out_item_t;

  // result kinds
  localparam logic [1:0] KIND_FIELD   = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;

  // end status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_TRUNC    = 3'd1;
  localparam logic [2:0] ST_WIRE     = 3'd2;
  localparam logic [2:0] ST_PORT     = 3'd3;
  localparam logic [2:0] ST_PAYLOAD  = 3'd4;
  localparam logic [2:0] ST_VARINT   = 3'd5;
  localparam logic [2:0] ST_BAD_WIRE = 3'd6;

  // register indexes
  localparam logic [0:0] REG_MAX_PAYLOAD = 1'd0;
  localparam logic [0:0] REG_MAX_PORT    = 1'd1;

  localparam int CFG_DATA_W = 16;

  // one front-end step yields up to two results
  typedef struct packed {
    logic      has_first;
    out_item_t first;
    logic      has_end;
    out_item_t end_item;
  } step_t;

endpackage
`default_nettype wire

>>> rtl/tmsd_front.sv
`default_nettype none
module tmsd_front #(
  parameter int MAX_MESSAGE_BYTES = 256
) (
  input  wire                logic clk,
  input  wire                logic rst,
  input  wire                logic cfg_we,
  input  wire                logic [0:0] cfg_index,
  input  wire                logic [tmsd_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire                logic in_fire,
  input  wire tmsd_pkg::in_item_t in_item,
  output tmsd_pkg::step_t    step
);
  import tmsd_pkg::*;

  typedef enum logic [2:0] {
    PH_TAG, PH_VARINT, PH_LEN, PH_FIXED, PH_SKIP, PH_PAYLOAD
  } phase_t;

  localparam int RemW = 16;

  phase_t      parse_phase, parse_phase_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  vcount, vcount_next;
  logic [7:0]  cur_field, cur_field_next;
  logic [RemW-1:0] remaining, remaining_next;
  logic [31:0] fixed_word, fixed_word_next;
  logic [2:0]  err, err_next;
  logic [7:0]  max_payload_len;
  logic [15:0] max_port_number;

  logic [7:0]  b;
  logic [63:0] v;
  logic [6:0]  shamt;
  logic [1:0]  fidx;
  logic [2:0]  wire_t;
  logic [7:0]  fnum;
  logic [2:0]  st;
  out_item_t   first;
  logic        has_first;

  assign b = in_item.data_byte;

  always_comb begin
    parse_phase_next = parse_phase;
    acc_next         = acc;
    vcount_next      = vcount;
    cur_field_next   = cur_field;
    remaining_next   = remaining;
    fixed_word_next  = fixed_word;
    err_next         = err;
    has_first        = 1'b0;
    first            = '0;
    v                = '0;
    shamt            = 7'(7 * vcount);
    fidx             = 2'(3'd4 - remaining[2:0]);
    wire_t           = '0;
    fnum             = '0;
    st               = ST_OK;
    if (err == ST_OK) begin
      case (parse_phase)
        PH_TAG, PH_VARINT, PH_LEN: begin
          // accumulate the varint
          v = acc;
          if (vcount <= 4'd9) v = acc | ({57'd0, b[6:0]} << shamt[5:0]);
          vcount_next = vcount + 4'd1;
          acc_next    = v;
          if (b[7]) begin
            if (vcount_next >= 4'd10) err_next = ST_VARINT;
          end else begin
            acc_next    = '0;
            vcount_next = '0;
            if (parse_phase == PH_TAG) begin
              fnum   = v[10:3];
              wire_t = v[2:0];
              cur_field_next = fnum;
              case (fnum)
                8'd1, 8'd3, 8'd9:
                  if (wire_t != 3'd0) err_next = ST_WIRE;
                  else parse_phase_next = PH_VARINT;
                8'd2:
                  if (wire_t != 3'd2) err_next = ST_WIRE;
                  else parse_phase_next = PH_LEN;
                8'd4, 8'd5, 8'd6, 8'd7, 8'd8:
                  if (wire_t != 3'd5) err_next = ST_WIRE;
                  else begin
                    parse_phase_next = PH_FIXED;
                    remaining_next   = RemW'(4);
                    fixed_word_next  = '0;
                  end
                default:
                  case (wire_t)
                    3'd0: parse_phase_next = PH_VARINT;
                    3'd1: begin
                      parse_phase_next = PH_SKIP;
                      remaining_next   = RemW'(8);
                    end
                    3'd2: parse_phase_next = PH_LEN;
                    3'd5: begin
                      parse_phase_next = PH_SKIP;
                      remaining_next   = RemW'(4);
                    end
                    default: err_next = ST_BAD_WIRE;
                  endcase
              endcase
            end else if (parse_phase == PH_VARINT) begin
              parse_phase_next   = PH_TAG;
              first.item_kind    = KIND_FIELD;
              first.field_number = cur_field[3:0];
              if (cur_field == 8'd1) begin
                if (v > {48'd0, max_port_number}) err_next = ST_PORT;
                else begin
                  has_first = 1'b1;
                  first.field_value = v[31:0];
                end
              end else if (cur_field == 8'd3) begin
                has_first = 1'b1;
                first.field_value = {31'd0, v != 64'd0};
              end else if (cur_field == 8'd9) begin
                has_first = 1'b1;
                first.field_value = v[31:0];
              end
            end else if (cur_field == 8'd2) begin
              if (v > {56'd0, max_payload_len}) err_next = ST_PAYLOAD;
              else begin
                has_first          = 1'b1;
                first.item_kind    = KIND_FIELD;
                first.field_number = 4'd2;
                first.field_value  = v[31:0];
                if (v == 64'd0) parse_phase_next = PH_TAG;
                else begin
                  parse_phase_next = PH_PAYLOAD;
                  remaining_next   = RemW'(v[7:0]);
                end
              end
            end else begin
              if (v > 64'(MAX_MESSAGE_BYTES)) err_next = ST_TRUNC;
              else if (v == 64'd0) parse_phase_next = PH_TAG;
              else begin
                parse_phase_next = PH_SKIP;
                remaining_next   = v[RemW-1:0];
              end
            end
          end
        end
        PH_FIXED: begin
          // gather little-endian word
          fixed_word_next = fixed_word | ({24'd0, b} << {fidx, 3'd0});
          remaining_next  = remaining - RemW'(1);
          if (remaining_next == '0) begin
            has_first          = 1'b1;
            first.item_kind    = KIND_FIELD;
            first.field_number = cur_field[3:0];
            first.field_value  = fixed_word_next;
            fixed_word_next    = '0;
            parse_phase_next   = PH_TAG;
          end
        end
        default: begin
          // payload or skip: count down
          if (parse_phase == PH_PAYLOAD) begin
            has_first          = 1'b1;
            first.item_kind    = KIND_PAYLOAD;
            first.field_number = 4'd2;
            first.field_value  = {24'd0, b};
          end
          remaining_next = remaining - RemW'(1);
          if (remaining_next == '0) parse_phase_next = PH_TAG;
        end
      endcase
    end
    // end-of-message status
    st = err_next;
    if (st == ST_OK && (parse_phase_next != PH_TAG || vcount_next != 4'd0)) st = ST_TRUNC;
    step.has_first           = has_first;
    step.first               = first;
    step.first.last_of_run   = !in_item.end_of_message;
    step.has_end             = in_item.end_of_message;
    step.end_item            = '0;
    step.end_item.item_kind  = KIND_END;
    step.end_item.end_status = st;
    step.end_item.last_of_run = 1'b1;
  end

  // hold parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase     <= PH_TAG;
      acc             <= '0;
      vcount          <= '0;
      cur_field       <= '0;
      remaining       <= '0;
      fixed_word      <= '0;
      err             <= ST_OK;
      max_payload_len <= 8'd233;
      max_port_number <= 16'd511;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_PAYLOAD: max_payload_len <= cfg_data[7:0];
          REG_MAX_PORT:    max_port_number <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire) begin
        if (in_item.end_of_message) begin
          parse_phase <= PH_TAG;
          acc         <= '0;
          vcount      <= '0;
          cur_field   <= '0;
          remaining   <= '0;
          fixed_word  <= '0;
          err         <= ST_OK;
        end else begin
          parse_phase <= parse_phase_next;
          acc         <= acc_next;
          vcount      <= vcount_next;
          cur_field   <= cur_field_next;
          remaining   <= remaining_next;
          fixed_word  <= fixed_word_next;
          err         <= err_next;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/tmsd_queue.sv
`default_nettype none
module tmsd_queue (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire tmsd_pkg::out_item_t push_item,
  output logic      full_soon,
  output logic      out_valid,
  output tmsd_pkg::out_item_t out_item,
  input  wire logic out_stall
);
  import tmsd_pkg::*;

  localparam int Depth = 4;

  out_item_t  slots [Depth];
  logic [1:0] rd_ptr, wr_ptr;
  logic [2:0] count;
  logic       pop;

  assign out_valid = count != 3'd0;
  assign out_item  = slots[rd_ptr];
  assign pop       = out_valid && !out_stall;
  // room for two more results after this cycle
  assign full_soon = count > 3'd2;

  // hold queue entries
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_item;
  end

  // advance pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + {2'd0, push} - {2'd0, pop};
    end
  end

endmodule
`default_nettype wire

>>> rtl/tmsd_back.sv
`default_nettype none
module tmsd_back (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic step_valid,
  input  wire tmsd_pkg::step_t step,
  output logic      busy,
  output logic      push,
  output tmsd_pkg::out_item_t push_item,
  input  wire logic full_soon
);
  import tmsd_pkg::*;

  // pending end item when a step gives two results
  logic      pend;
  out_item_t pend_item;

  assign busy = pend || full_soon;

  always_comb begin
    push      = 1'b0;
    push_item = step.first;
    if (pend) begin
      push      = 1'b1;
      push_item = pend_item;
    end else if (step_valid) begin
      if (step.has_first) begin
        push = 1'b1;
      end else if (step.has_end) begin
        push      = 1'b1;
        push_item = step.end_item;
      end
    end
  end

  // hold second result and push it in the following cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else if (pend) begin
      pend <= 1'b0;
    end else if (step_valid && step.has_first && step.has_end) begin
      pend <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (step_valid) pend_item <= step.end_item;
  end

endmodule
`default_nettype wire

>>> rtl/tagged_message_stream_decoder_unit.sv
`default_nettype none
// channel | direction | handshake       | payload
// in      | into      | in_valid/in_stall   | in_item (data_byte, end_of_message)
// out     | out of    | out_valid/out_stall | out_item (kind, field, value, status)
// cfg     | into      | cfg_we              | cfg_index, cfg_data
// One byte is taken per cycle while in_stall is low; results go through a four-entry queue.
// A byte giving a field plus the end item pushes them one after the other
// through the single queue write port, so in_stall rises for one cycle.
// in_stall is also high while the queue holds three or more results.
// Synchronous reset clears parser and queue and sets the registers to their defaults.
module tagged_message_stream_decoder_unit #(
  parameter int MAX_MESSAGE_BYTES = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire tmsd_pkg::in_item_t in_item,
  output logic      out_valid,
  input  wire logic out_stall,
  output tmsd_pkg::out_item_t out_item,
  input  wire logic cfg_we,
  input  wire logic [0:0] cfg_index,
  input  wire logic [tmsd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tmsd_pkg::*;

  logic      in_fire, busy, push, full_soon;
  step_t     step;
  out_item_t push_item;

  assign in_stall = busy;
  assign in_fire  = in_valid && !in_stall;

  tmsd_front #(.MAX_MESSAGE_BYTES(MAX_MESSAGE_BYTES)) u_front (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_fire, .in_item, .step
  );

  tmsd_back u_back (
    .clk, .rst, .step_valid(in_fire), .step, .busy,
    .push, .push_item, .full_soon
  );

  tmsd_queue u_queue (
    .clk, .rst, .push, .push_item, .full_soon,
    .out_valid, .out_item, .out_stall
  );

endmodule
`default_nettype wire

>>> dv/tb_tagged_message_stream_decoder_unit.sv
`default_nettype none
module tb_tagged_message_stream_decoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import tmsd_pkg::*;

  localparam int MSG_LIMIT = 256;
  localparam int STALL_LIMIT = 4000;

  typedef enum logic [2:0] {
    P_TAG = 3'd0, P_VARINT = 3'd1, P_LEN = 3'd2, P_FIXED = 3'd3,
    P_SKIP = 3'd4, P_PAYLOAD = 3'd5
  } phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  tagged_message_stream_decoder_unit #(.MAX_MESSAGE_BYTES(MSG_LIMIT)) DUT (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // decoder mirror state
  logic [7:0]  lim_payload;
  logic [15:0] lim_port;
  phase_t      ph;
  logic [63:0] acc;
  logic [3:0]  vcount;
  logic [7:0]  cur_field;
  logic [2:0]  cur_wire;
  logic [15:0] remaining;
  logic [31:0] word;
  logic [2:0]  err;

  out_item_t pending_results[$];
  int mismatches = 0;
  int bytes_sent = 0;
  int results_seen = 0;
  int messages_sent = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  task automatic clear_parser();
    ph = P_TAG; acc = '0; vcount = '0; cur_field = '0; cur_wire = '0;
    remaining = '0; word = '0; err = ST_OK;
  endtask

  function automatic out_item_t mk(logic [1:0] k, logic [3:0] f, logic [31:0] v,
                                   logic [2:0] s);
    out_item_t r;
    r.item_kind = k; r.field_number = f; r.field_value = v;
    r.end_status = s; r.last_of_run = 1'b0;
    return r;
  endfunction

  task automatic take_tag(logic [63:0] tag);
    cur_field = tag[10:3];
    cur_wire = tag[2:0];
    acc = '0; vcount = '0;
    case (cur_field)
      8'd1, 8'd3, 8'd9: if (cur_wire != 3'd0) err = ST_WIRE; else ph = P_VARINT;
      8'd2: if (cur_wire != 3'd2) err = ST_WIRE; else ph = P_LEN;
      8'd4, 8'd5, 8'd6, 8'd7, 8'd8: begin
        if (cur_wire != 3'd5) err = ST_WIRE;
        else begin
          ph = P_FIXED; remaining = 16'd4; word = '0;
        end
      end
      default: begin
        case (cur_wire)
          3'd0: ph = P_VARINT;
          3'd1: begin ph = P_SKIP; remaining = 16'd8; end
          3'd2: ph = P_LEN;
          3'd5: begin ph = P_SKIP; remaining = 16'd4; end
          default: err = ST_BAD_WIRE;
        endcase
      end
    endcase
  endtask

  // work out the results one byte causes and queue them
  task automatic predict_byte(in_item_t it);
    out_item_t res[$];
    logic [7:0] b;
    logic [6:0] shift;
    logic [63:0] v;
    logic [2:0] st;
    logic [1:0] idx;
    b = it.data_byte;
    if (err == ST_OK) begin
      if (ph == P_TAG || ph == P_VARINT || ph == P_LEN) begin
        shift = 7'(7 * vcount);
        if (shift < 64) acc = acc | (64'(b[6:0]) << shift);
        vcount = vcount + 4'd1;
        if (b[7] && vcount >= 4'd10) err = ST_VARINT;
        else if (!b[7]) begin
          v = acc; acc = '0; vcount = '0;
          if (ph == P_TAG) take_tag(v);
          else if (ph == P_VARINT) begin
            ph = P_TAG;
            if (cur_field == 8'd1) begin
              if (v > 64'(lim_port)) err = ST_PORT;
              else res.push_back(mk(KIND_FIELD, 4'd1, v[31:0], ST_OK));
            end else if (cur_field == 8'd3)
              res.push_back(mk(KIND_FIELD, 4'd3, {31'd0, v != 0}, ST_OK));
            else if (cur_field == 8'd9)
              res.push_back(mk(KIND_FIELD, 4'd9, v[31:0], ST_OK));
          end else if (cur_field == 8'd2) begin
            if (v > 64'(lim_payload)) err = ST_PAYLOAD;
            else begin
              res.push_back(mk(KIND_FIELD, 4'd2, v[31:0], ST_OK));
              if (v == 0) ph = P_TAG;
              else begin ph = P_PAYLOAD; remaining = v[15:0]; end
            end
          end else begin
            if (v > 64'(MSG_LIMIT)) err = ST_TRUNC;
            else if (v == 0) ph = P_TAG;
            else begin ph = P_SKIP; remaining = v[15:0]; end
          end
        end
      end else if (ph == P_FIXED) begin
        idx = 2'(3'd4 - remaining[2:0]);
        word = word | (32'(b) << (8 * idx));
        remaining = remaining - 16'd1;
        if (remaining == 0) begin
          res.push_back(mk(KIND_FIELD, cur_field[3:0], word, ST_OK));
          word = '0; ph = P_TAG;
        end
      end else begin
        if (ph == P_PAYLOAD) res.push_back(mk(KIND_PAYLOAD, 4'd2, 32'(b), ST_OK));
        remaining = remaining - 16'd1;
        if (remaining == 0) ph = P_TAG;
      end
    end
    if (it.end_of_message) begin
      st = err;
      if (st == ST_OK && (ph != P_TAG || vcount != 0)) st = ST_TRUNC;
      res.push_back(mk(KIND_END, 4'd0, 32'd0, st));
      clear_parser();
    end
    if (res.size() > 0) res[res.size()-1].last_of_run = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
  endtask

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    $display("MISMATCH %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
  endtask

  // compare each result transfer with the oldest expectation
  always @(posedge clk) begin
    out_item_t w;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0)
        report_mismatch("unexpected result", out_item.field_value, 32'd0);
      else begin
        w = pending_results.pop_front();
        if (out_item.item_kind != w.item_kind)
          report_mismatch("item_kind", 32'(out_item.item_kind), 32'(w.item_kind));
        if (out_item.field_number != w.field_number)
          report_mismatch("field_number", 32'(out_item.field_number), 32'(w.field_number));
        if (out_item.field_value != w.field_value)
          report_mismatch("field_value", out_item.field_value, w.field_value);
        if (out_item.end_status != w.end_status)
          report_mismatch("end_status", 32'(out_item.end_status), 32'(w.end_status));
        if (out_item.last_of_run != w.last_of_run)
          report_mismatch("last_of_run", 32'(out_item.last_of_run), 32'(w.last_of_run));
      end
      results_seen++;
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    int left;
    if (quiet) begin
      out_stall <= 1'b0; left = 0;
    end else if (left > 0) begin
      left--; if (left == 0) out_stall <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      left = $urandom_range(1, 13); out_stall <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Watchdog expired");
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_byte(logic [7:0] b, logic eom);
    in_item_t it;
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 13);
      repeat (gap) @(posedge clk);
    end
    it.data_byte = b; it.end_of_message = eom;
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(it);
    bytes_sent++;
    if (eom) messages_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    if (idx == REG_MAX_PAYLOAD) lim_payload = val[7:0];
    else lim_port = val;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_varint(logic [63:0] v, int extra);
    do begin
      send_byte({(v > 127) || (extra > 0), v[6:0]}, 1'b0);
      v = v >> 7;
    end while (v != 0);
    while (extra > 0) begin
      extra--; send_byte({extra > 0, 7'd0}, 1'b0);
    end
  endtask

  // one field with random content, not always well-formed; returns nothing, just streams
  task automatic send_field();
    int f;
    int n;
    f = $urandom_range(1, 12);
    case (f)
      1: begin
        send_byte(8'h08, 1'b0);
        send_varint($urandom_range(0, 3) == 0 ? {$urandom, $urandom}
                    : 64'($urandom_range(0, 32'(lim_port) + 4)), 0);
      end
      2: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 6);
        send_byte(8'h12, 1'b0);
        send_varint(64'(n), 0);
        if (n <= lim_payload) repeat (n) send_byte(8'($urandom), 1'b0);
      end
      3, 9: begin
        send_byte(f == 3 ? 8'h18 : 8'h48, 1'b0);
        send_varint($urandom_range(0, 1) ? 64'($urandom_range(0, 2)) : {$urandom, $urandom},
                    $urandom_range(0, 15) == 0 ? 1 : 0);
      end
      4, 5, 6, 7, 8: begin
        send_byte(8'((f << 3) | 5), 1'b0);
        repeat (4) send_byte(8'($urandom), 1'b0);
      end
      default: begin
        send_varint(64'(($urandom_range(10, 300) << 3) | $urandom_range(0, 7)), 0);
      end
    endcase
  endtask

  typedef struct { logic [7:0] b; logic eom; logic chk; out_item_t want; } row_t;
  row_t rows[$];

  function automatic row_t r(logic [7:0] b, logic eom);
    row_t x;
    x.b = b; x.eom = eom; x.chk = 1'b0; x.want = '0;
    return x;
  endfunction

  function automatic row_t re(logic [7:0] b, logic [2:0] st);
    row_t x;
    x.b = b; x.eom = 1'b1; x.chk = 1'b1;
    x.want = mk(KIND_END, 4'd0, 32'd0, st);
    x.want.last_of_run = 1'b1;
    return x;
  endfunction

  initial begin
    int m;
    int k;
    clear_parser();
    lim_payload = 8'd233; lim_port = 16'd511;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed table: error codes and extremes
    rows = {
      re(8'h00, ST_TRUNC), re(8'hFF, ST_TRUNC),
      r(8'h08, 0), r(8'hFF, 0), re(8'h03, ST_OK),
      r(8'h08, 0), r(8'h80, 0), re(8'h04, ST_PORT),
      re(8'h09, ST_WIRE),
      r(8'h12, 0), r(8'hEA, 0), re(8'h01, ST_PAYLOAD),
      r(8'h12, 0), r(8'h02, 0), r(8'h00, 0), re(8'hFF, ST_OK),
      r(8'h25, 0), r(8'h01, 0), re(8'h02, ST_TRUNC),
      re(8'h53, ST_BAD_WIRE),
      r(8'h52, 0), r(8'h81, 0), re(8'h02, ST_TRUNC),
      r(8'h18, 0), re(8'h80, ST_TRUNC)
    };
    foreach (rows[i]) begin
      send_byte(rows[i].b, rows[i].eom);
      // the end item of a checked row is the typed-in one
      if (rows[i].chk) begin
        void'(pending_results.pop_back());
        pending_results.push_back(rows[i].want);
      end
    end
    // overlong varint on a tag: ten continuation bytes
    repeat (10) send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    drain();

    // random messages under several register settings
    for (int phase_i = 0; phase_i < 5; phase_i++) begin
      case (phase_i)
        0: begin write_reg(REG_MAX_PAYLOAD, 16'd0); write_reg(REG_MAX_PORT, 16'd0); end
        1: begin write_reg(REG_MAX_PAYLOAD, 16'd255); write_reg(REG_MAX_PORT, 16'hFFFF); end
        2: begin write_reg(REG_MAX_PAYLOAD, 16'd4); write_reg(REG_MAX_PORT, 16'd100); end
        3: begin
          write_reg(REG_MAX_PAYLOAD, 16'($urandom));
          write_reg(REG_MAX_PORT, 16'($urandom));
        end
        default: begin write_reg(REG_MAX_PAYLOAD, 16'd233); write_reg(REG_MAX_PORT, 16'd511); end
      endcase
      if (phase_i == 4) quiet = 1'b1;
      m = bytes_sent + 200;
      while (bytes_sent < m) begin
        k = $urandom_range(0, 4);
        if ($urandom_range(0, 9) == 0) begin
          // noise, including broken sequences
          repeat ($urandom_range(1, 8)) send_byte(8'($urandom), 1'b0);
        end else repeat (k) send_field();
        send_byte($urandom_range(0, 3) == 0 ? 8'($urandom) : 8'h00, 1'b1);
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Sent %0d bytes in %0d messages, checked %0d results", bytes_sent,
             messages_sent, results_seen);
    $display("Covered every field, all end codes and five register settings");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
